>>> rtl/m3i_pkg.sv
// Shared types and constant tables for the 3x3 matrix inverse block.
`default_nettype none
package m3i_pkg;

  localparam int unsigned NUM_ELEM = 9;
  localparam int unsigned NUM_PROD = 18;
  localparam int unsigned Q_DEPTH  = 4;

  // Per-item flags that travel from the front end to the divider
  typedef struct packed {
    logic                singular;
    logic [NUM_ELEM-1:0] neg;
  } m3i_flags_t;

  localparam int unsigned FLAGS_W = $bits(m3i_flags_t);

  // Cofactor k = m[a]*m[b] - m[c]*m[d], element indices in row-major order
  localparam int unsigned COF_IDX [NUM_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // Cofactors of the first row elements, used for the determinant
  localparam int unsigned DET_COF [3] = '{0, 3, 6};

endpackage
`default_nettype wire

>>> rtl/m3i_front.sv
// Front end: cofactors, determinant, magnitudes and sign flags.
`default_nettype none
module m3i_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] m_i [m3i_pkg::NUM_ELEM],
  output logic                         q_valid_o,
  input  logic                         q_ready_i,
  output logic [m3i_pkg::FLAGS_W + (3*DATA_WIDTH+3)
                + m3i_pkg::NUM_ELEM*(2*DATA_WIDTH+1) - 1:0] q_data_o
);
  import m3i_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned DW = 3 * W + 3;

  logic [3:0] v_q;
  logic       en;

  logic signed [PW-1:0] p_d  [NUM_PROD];
  logic signed [PW-1:0] p_q  [NUM_PROD];
  logic signed [W-1:0]  mr1_q [3];
  logic signed [W-1:0]  mr2_q [3];
  logic signed [CW-1:0] c_d  [NUM_ELEM];
  logic signed [CW-1:0] c2_q [NUM_ELEM];
  logic signed [CW-1:0] c3_q [NUM_ELEM];
  logic signed [CW-1:0] c4_q [NUM_ELEM];
  logic signed [CW-1:0] plo_d [3];
  logic signed [CW-1:0] phi_d [3];
  logic signed [CW-1:0] plo_q [3];
  logic signed [CW-1:0] phi_q [3];
  logic signed [DW-1:0] det_d;
  logic signed [DW-1:0] det_q;
  logic [CW-1:0]        cabs [NUM_ELEM];
  logic [DW-1:0]        dabs;
  m3i_flags_t           flags;

  // Advance the whole pipe unless the last stage is blocked
  assign en         = ~v_q[3] | q_ready_i;
  assign in_ready_o = en;
  assign q_valid_o  = v_q[3];

  // Products of element pairs
  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      p_d[2*k]   = m_i[COF_IDX[k][0]] * m_i[COF_IDX[k][1]];
      p_d[2*k+1] = m_i[COF_IDX[k][2]] * m_i[COF_IDX[k][3]];
    end
  end

  // Cofactors as differences of products
  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      c_d[k] = CW'(p_q[2*k]) - CW'(p_q[2*k+1]);
    end
  end

  // Split first-row cofactors into halves to keep multipliers narrow
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      plo_d[j] = mr2_q[j] * $signed({1'b0, c2_q[DET_COF[j]][W-1:0]});
      phi_d[j] = mr2_q[j] * $signed(c2_q[DET_COF[j]][CW-1:W]);
    end
  end

  // Recombine the partial products into the determinant
  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DW'(phi_q[j]) <<< W) + DW'(plo_q[j]);
    end
  end

  // Magnitudes and result signs
  always_comb begin
    dabs           = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    flags.singular = (det_q == '0);
    for (int k = 0; k < NUM_ELEM; k++) begin
      cabs[k]      = c4_q[k][CW-1] ? CW'(-c4_q[k]) : CW'(c4_q[k]);
      flags.neg[k] = c4_q[k][CW-1] ^ det_q[DW-1];
    end
  end

  // Pack one queue entry, cofactor 0 in the low bits
  always_comb begin
    q_data_o = '0;
    for (int k = 0; k < NUM_ELEM; k++) begin
      q_data_o[k*CW +: CW] = cabs[k];
    end
    q_data_o[NUM_ELEM*CW +: DW]      = dabs;
    q_data_o[NUM_ELEM*CW + DW +: FLAGS_W] = flags;
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q   <= p_d;
      mr1_q <= m_i[0:2];
      c2_q  <= c_d;
      mr2_q <= mr1_q;
      plo_q <= plo_d;
      phi_q <= phi_d;
      c3_q  <= c2_q;
      det_q <= det_d;
      c4_q  <= c3_q;
    end
  end

endmodule
`default_nettype wire

>>> rtl/m3i_fifo.sv
// Short queue between the front end and the divider.
`default_nettype none
module m3i_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);
  import m3i_pkg::*;

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [Q_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

>>> rtl/m3i_back.sv
// Back end: pipelined restoring division, one quotient bit per stage, and saturation.
`default_nettype none
module m3i_back #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  logic [m3i_pkg::FLAGS_W + (3*DATA_WIDTH+3)
                + m3i_pkg::NUM_ELEM*(2*DATA_WIDTH+1) - 1:0] q_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] inv_o [m3i_pkg::NUM_ELEM],
  output logic                  singular_o
);
  import m3i_pkg::*;

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned CW  = 2 * W + 1;
  localparam int unsigned DW  = 3 * W + 3;
  localparam int unsigned NW  = CW + 2 * FRAC_BITS;
  localparam int unsigned DWS = DW + W;
  localparam int unsigned RW  = (NW > DWS) ? NW : DWS;
  localparam logic [W-1:0] LIM  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXP = ~LIM;

  logic                en;
  logic [CW-1:0]       cabs [NUM_ELEM];
  logic [DW-1:0]       dabs;
  m3i_flags_t          flags_in;
  logic [NUM_ELEM-1:0] big_d;

  logic [W-1:0]        v_q;
  logic [RW-1:0]       r_q   [W][NUM_ELEM];
  logic [W-1:0]        qt_q  [W][NUM_ELEM];
  logic [DW-1:0]       d_q   [W];
  m3i_flags_t          fl_q  [W];
  logic [NUM_ELEM-1:0] big_q [W];
  logic [RW-1:0]       r_n   [W-1][NUM_ELEM];
  logic [W-1:0]        qt_n  [W][NUM_ELEM];

  logic                out_valid_q;
  logic [W-1:0]        inv_d [NUM_ELEM];
  logic [W-1:0]        inv_q [NUM_ELEM];
  logic                sing_q;

  // Advance the divider unless the output register is held
  assign en          = ~out_valid_q | out_ready_i;
  assign q_ready_o   = en;
  assign out_valid_o = out_valid_q;
  assign inv_o       = inv_q;
  assign singular_o  = sing_q;

  // Unpack the entry and flag quotients that cannot fit in W bits
  always_comb begin
    dabs     = q_data_i[NUM_ELEM*CW +: DW];
    flags_in = q_data_i[NUM_ELEM*CW + DW +: FLAGS_W];
    for (int l = 0; l < NUM_ELEM; l++) begin
      cabs[l]  = q_data_i[l*CW +: CW];
      big_d[l] = (RW'(cabs[l]) << (2 * FRAC_BITS)) >= (RW'(dabs) << W);
    end
  end

  // One trial subtraction per stage, most significant bit first
  always_comb begin
    for (int k = 0; k < W; k++) begin
      for (int l = 0; l < NUM_ELEM; l++) begin
        qt_n[k][l] = {qt_q[k][l][W-2:0],
                      r_q[k][l] >= (RW'(d_q[k]) << (W - 1 - k))};
      end
    end
    for (int k = 0; k < W - 1; k++) begin
      for (int l = 0; l < NUM_ELEM; l++) begin
        r_n[k][l] = qt_n[k][l][0] ? r_q[k][l] - (RW'(d_q[k]) << (W - 1 - k))
                                  : r_q[k][l];
      end
    end
  end

  // Apply sign, clamp to range, zero out singular results
  always_comb begin
    for (int l = 0; l < NUM_ELEM; l++) begin
      if (fl_q[W-1].singular) begin
        inv_d[l] = '0;
      end else if (fl_q[W-1].neg[l]) begin
        inv_d[l] = (big_q[W-1][l] || qt_n[W-1][l] > LIM) ? LIM : -qt_n[W-1][l];
      end else begin
        inv_d[l] = (big_q[W-1][l] || qt_n[W-1][l] > MAXP) ? MAXP : qt_n[W-1][l];
      end
    end
  end

  // Stage and output valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[W-2:0], q_valid_i};
      out_valid_q <= v_q[W-1];
    end
  end

  // Stage payload and output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NUM_ELEM; l++) begin
        r_q[0][l]  <= RW'(cabs[l]) << (2 * FRAC_BITS);
        qt_q[0][l] <= '0;
      end
      d_q[0]   <= dabs;
      fl_q[0]  <= flags_in;
      big_q[0] <= big_d;
      for (int k = 1; k < W; k++) begin
        r_q[k]   <= r_n[k-1];
        qt_q[k]  <= qt_n[k-1];
        d_q[k]   <= d_q[k-1];
        fl_q[k]  <= fl_q[k-1];
        big_q[k] <= big_q[k-1];
      end
      inv_q  <= inv_d;
      sing_q <= fl_q[W-1].singular;
    end
  end

endmodule
`default_nettype wire

>>> rtl/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse: front end, queue and divider.
`default_nettype none
// Inverts one 3x3 signed fixed-point matrix (FRAC_BITS fraction bits) per
// transfer by the adjugate method: exact cofactors and determinant, then each
// cofactor divided by the determinant, truncated toward zero and clamped to the
// DATA_WIDTH range. A zero determinant gives singular_o = 1 and all zeros. The
// block takes one matrix every cycle when the output is not stalled; the
// divider resolves one quotient bit per pipeline stage for all nine elements
// in parallel. A four-entry queue between the cofactor pipeline and the
// divider lets each side stall alone.
module matrix3x3_inverse #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] m00_i,
  input  logic signed [DATA_WIDTH-1:0] m01_i,
  input  logic signed [DATA_WIDTH-1:0] m02_i,
  input  logic signed [DATA_WIDTH-1:0] m10_i,
  input  logic signed [DATA_WIDTH-1:0] m11_i,
  input  logic signed [DATA_WIDTH-1:0] m12_i,
  input  logic signed [DATA_WIDTH-1:0] m20_i,
  input  logic signed [DATA_WIDTH-1:0] m21_i,
  input  logic signed [DATA_WIDTH-1:0] m22_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] inv00_o,
  output logic signed [DATA_WIDTH-1:0] inv01_o,
  output logic signed [DATA_WIDTH-1:0] inv02_o,
  output logic signed [DATA_WIDTH-1:0] inv10_o,
  output logic signed [DATA_WIDTH-1:0] inv11_o,
  output logic signed [DATA_WIDTH-1:0] inv12_o,
  output logic signed [DATA_WIDTH-1:0] inv20_o,
  output logic signed [DATA_WIDTH-1:0] inv21_o,
  output logic signed [DATA_WIDTH-1:0] inv22_o,
  output logic                         singular_o
);
  import m3i_pkg::*;

  localparam int unsigned QW = FLAGS_W + (3 * DATA_WIDTH + 3)
                               + NUM_ELEM * (2 * DATA_WIDTH + 1);

  logic signed [DATA_WIDTH-1:0] m [NUM_ELEM];
  logic [DATA_WIDTH-1:0]        inv [NUM_ELEM];
  logic                         f_valid, f_ready;
  logic [QW-1:0]                f_data;
  logic                         b_valid, b_ready;
  logic [QW-1:0]                b_data;

  assign m = '{m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i};

  m3i_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .m_i(m), .q_valid_o(f_valid), .q_ready_i(f_ready), .q_data_o(f_data)
  );

  m3i_fifo #(.DATA_W(QW)) u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_data_i(f_data),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_data_o(b_data)
  );

  m3i_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(b_valid), .q_ready_o(b_ready), .q_data_i(b_data),
    .out_valid_o, .out_ready_i, .inv_o(inv), .singular_o
  );

  assign inv00_o = $signed(inv[0]);
  assign inv01_o = $signed(inv[1]);
  assign inv02_o = $signed(inv[2]);
  assign inv10_o = $signed(inv[3]);
  assign inv11_o = $signed(inv[4]);
  assign inv12_o = $signed(inv[5]);
  assign inv20_o = $signed(inv[6]);
  assign inv21_o = $signed(inv[7]);
  assign inv22_o = $signed(inv[8]);

`ifndef ASSERT_OFF
  // A singular result carries all-zero elements
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |->
      inv00_o == 0 && inv01_o == 0 && inv02_o == 0 && inv10_o == 0 &&
      inv11_o == 0 && inv12_o == 0 && inv20_o == 0 && inv21_o == 0 &&
      inv22_o == 0)
    else $error("singular result with nonzero elements");

  // A front-end item blocked by a full queue is not dropped
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid && !f_ready |=> f_valid)
    else $error("front-end item lost while queue full");

  // An empty queue that receives no push does not show an entry
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !f_valid && !b_valid |=> !b_valid)
    else $error("queue shows an entry that was never written");
`endif

endmodule
`default_nettype wire
